/* rtl/mvt_pkg.sv */
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the matrix-vector transform
// Action codes, operand bundles and pipeline stage enables.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int WORD_W       = 32;
    localparam int PROD_W       = 64;
    localparam int PAIR_W       = 65;
    localparam int SUM_W        = 66;
    localparam int EPS_W        = 16;
    localparam int LANES        = 4;
    localparam int MATRIX_ELEMS = 16;

    // action codes; code 3 means nothing and is dropped
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_COL  = 2'd1;
    localparam logic [1:0] ACT_ROW  = 2'd2;

    // register index decoded from paddr[2]
    localparam logic REG_ZERO_EPS = 1'b0;

    // four 32-bit words, word 0 in the low bits
    typedef logic [LANES-1:0][WORD_W-1:0] t_quad;

    // load enables of the lane stages
    typedef struct packed {
        logic s2;   // products
        logic s3;   // pair sums
        logic s4;   // full sum
    } t_stage_en;

endpackage

/* rtl/matrix_vector_transform.sv */
// ----------------------------------------------------------------------------
// matrix_vector_transform: 4x4 Q16.16 matrix-vector transform engine
// Holds a column-major matrix (identity after reset); loads elements and
// returns M*v or v*M with truncation, saturation and zero snapping.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: action; tdata: index, value, x..w
//  m_*      out  m_tvalid/m_tready  tdata: out_x, out_y, out_z, out_w
//  apb      in   psel&penable       pwrite/paddr/pwdata, prdata, pready=1
//
//  One beat per cycle sustained while the output is not stalled. A transform
//  beat passes operand select at its accepting edge, then multiply, pair
//  add, final add and rounding into the output register, raising m_tvalid.
//  Loads finish in the accept cycle and give no result, so a transform
//  right after a load sees the new element.
//  Stages advance independently and bubbles collapse; s_tready drops only
//  when every stage is full and the output beat is stalled.
//  Reset (synchronous, active low) restores the identity matrix and
//  zero_epsilon = 7 and empties the pipeline.
// ----------------------------------------------------------------------------
module matrix_vector_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [167:0]  s_tdata,  // elem_index[3:0], elem_value[35:4], vec_x[67:36],
                                    // vec_y[99:68], vec_z[131:100], vec_w[163:132], pad
    input  logic [1:0]    s_tuser,  // action[1:0]
    // result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import mvt_pkg::*;

    localparam logic [WORD_W-1:0] ONE_Q = WORD_W'(1) << FRAC_BITS;

    // input beat fields
    logic [1:0]        w_action;
    logic [3:0]        w_index;
    logic [WORD_W-1:0] w_value;
    t_quad             w_vec;
    logic              w_accept;

    assign w_action = s_tuser;
    assign w_index  = s_tdata[3:0];
    assign w_value  = s_tdata[35:4];
    assign w_vec    = s_tdata[163:36];
    assign w_accept = s_tvalid && s_tready;

    // matrix store, column-major
    logic [WORD_W-1:0] r_mat [MATRIX_ELEMS];

    // stage valids and enables
    logic r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic w_en1, w_out_en;
    t_stage_en w_en;

    // operand registers (stage 1)
    t_quad r_m_op [LANES];
    t_quad r_v_op;

    logic [EPS_W-1:0]  r_eps;
    logic [WORD_W-1:0] w_res [LANES];
    t_quad             r_out;

    // a stage loads when it is empty or the next one moves
    always_comb begin
        w_out_en = !r_out_valid || m_tready;
        w_en.s4  = !r_v4 || w_out_en;
        w_en.s3  = !r_v3 || w_en.s4;
        w_en.s2  = !r_v2 || w_en.s3;
        w_en1    = !r_v1 || w_en.s2;
    end

    assign s_tready = w_en1;

    // config port: single register, written on the access phase
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ZERO_EPS) ? {{(32-EPS_W){1'b0}}, r_eps} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_W'(7);
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ZERO_EPS)) begin
            r_eps <= pwdata[EPS_W-1:0];
        end
    end

    // matrix load; identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < MATRIX_ELEMS; e++) begin
                r_mat[e] <= ((e % 5) == 0) ? ONE_Q : '0;
            end
        end else if (w_accept && (w_action == ACT_LOAD)) begin
            r_mat[w_index] <= w_value;
        end
    end

    // control: valid bits for each stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= w_accept && ((w_action == ACT_COL) || (w_action == ACT_ROW));
            end
            if (w_en.s2) begin
                r_v2 <= r_v1;
            end
            if (w_en.s3) begin
                r_v3 <= r_v2;
            end
            if (w_en.s4) begin
                r_v4 <= r_v3;
            end
            if (w_out_en) begin
                r_out_valid <= r_v4;
            end
        end
    end

    // operand select: lane i takes row i (M*v) or column i (v*M)
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_v_op <= w_vec;
            for (int i = 0; i < LANES; i++) begin
                for (int j = 0; j < LANES; j++) begin
                    r_m_op[i][j] <= (w_action == ACT_COL) ? r_mat[i + 4*j] : r_mat[4*i + j];
                end
            end
        end
    end

    // dot-product lanes
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mvt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_m   (r_m_op[g]),
            .i_v   (r_v_op),
            .i_eps (r_eps),
            .o_res (w_res[g])
        );
    end

    // merge: the four lane results form one output beat
    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            for (int i = 0; i < LANES; i++) begin
                r_out[i] <= w_res[i];
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_out_valid && !m_tready))
        else $error("input stalled while the pipeline has room");

    a_transform_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && ((w_action == ACT_COL) || (w_action == ACT_ROW))) |=> r_v1)
        else $error("accepted transform beat did not enter the pipeline");

    a_load_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_action == ACT_LOAD)) |=> (r_mat[$past(w_index)] == $past(w_value)))
        else $error("matrix load not written");

    a_no_bubble_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && r_out_valid && !m_tready) |=> (r_v4 && r_out_valid))
        else $error("stalled result lost");

endmodule

/* rtl/mvt_lane.sv */
// ----------------------------------------------------------------------------
// mvt_lane: one dot-product lane
// Four products, a registered adder tree, then truncation toward zero,
// saturation and snapping of small results.
// ----------------------------------------------------------------------------
module mvt_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  mvt_pkg::t_stage_en            i_en,
    input  mvt_pkg::t_quad                i_m,
    input  mvt_pkg::t_quad                i_v,
    input  logic [mvt_pkg::EPS_W-1:0]     i_eps,
    output logic [mvt_pkg::WORD_W-1:0]    o_res
);
    import mvt_pkg::*;

    localparam logic signed [SUM_W-1:0] Q_MAX  = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] Q_MIN  = -SUM_W'(64'sd2147483648);
    localparam logic signed [SUM_W-1:0] BIAS   = (SUM_W'(1) << FRAC_BITS) - SUM_W'(1);

    logic signed [PROD_W-1:0] r_prod [LANES];
    logic signed [PAIR_W-1:0] r_pair [2];
    logic signed [SUM_W-1:0]  r_sum;

    logic signed [SUM_W-1:0]  w_adj;
    logic signed [SUM_W-1:0]  w_q;
    logic signed [SUM_W-1:0]  w_eps;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < LANES; j++) begin
            if (i_en.s2) begin
                r_prod[j] <= $signed(i_m[j]) * $signed(i_v[j]);
            end
        end
        if (i_en.s3) begin
            r_pair[0] <= PAIR_W'(r_prod[0]) + PAIR_W'(r_prod[1]);
            r_pair[1] <= PAIR_W'(r_prod[2]) + PAIR_W'(r_prod[3]);
        end
        if (i_en.s4) begin
            r_sum <= SUM_W'(r_pair[0]) + SUM_W'(r_pair[1]);
        end
    end

    // truncate toward zero: bias negative sums before the arithmetic shift
    always_comb begin
        w_adj = r_sum + (r_sum[SUM_W-1] ? BIAS : '0);
        w_q   = w_adj >>> FRAC_BITS;
        w_eps = $signed({{(SUM_W-EPS_W){1'b0}}, i_eps});
        if (w_q > Q_MAX) begin
            o_res = WORD_W'(Q_MAX);
        end else if (w_q < Q_MIN) begin
            o_res = WORD_W'(Q_MIN);
        end else if ((w_q <= w_eps) && (w_q >= -w_eps)) begin
            o_res = '0;
        end else begin
            o_res = w_q[WORD_W-1:0];
        end
    end

endmodule

/* dv/tb_matrix_vector_transform.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_vector_transform: self-checking bench for the 4x4 transform engine
// Streams load, M*v and v*M beats into the block and tracks its own copy of
// the matrix and zero_epsilon. Every output beat is checked lane by lane
// against the predicted vector. The APB register is reprogrammed between
// phases, and each side of the stream idles at random.
// ----------------------------------------------------------------------------
module tb_matrix_vector_transform;
    import mvt_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int STALL_LIMIT  = 3000;  // cycles with no traffic before giving up
    localparam int DRAIN_CYCLES = 12;    // pipeline is five deep, plus margin
    localparam int PHASE_BEATS  = 460;   // counted beats per random phase

    // tuser code the block drops
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // eps register address; the next word slot holds no register
    localparam logic [2:0] ADDR_ZERO_EPS = 3'd0;
    localparam logic [2:0] ADDR_NO_REG   = 3'd4;

    logic         i_clk;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata  = '0;  // elem_index, elem_value, vec_x, vec_y, vec_z, vec_w, pad
    logic [1:0]   s_tuser  = '0;  // action
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;        // out_x, out_y, out_z, out_w
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    // one input beat, as the bench sees it
    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  elem_index;
        logic [31:0] elem_value;
        t_quad       vec;
    } t_beat;

    // shadow state of the block
    logic [WORD_W-1:0] matrix_shadow [MATRIX_ELEMS];
    logic [EPS_W-1:0]  eps_shadow;

    t_quad pending_vectors [$];  // predicted output beats, oldest first

    int errors         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    matrix_vector_transform #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Exact four-term sum -> truncate toward zero -> snap -> saturate.
    // q is the truncated magnitude, so the snap test works on it directly;
    // saturated values are far above any 16-bit epsilon.
    function automatic logic [WORD_W-1:0] fold_sum(input logic signed [SUM_W-1:0] acc);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] q;
        mag = acc[SUM_W-1] ? -acc : acc;
        q   = mag >> FRAC_BITS;
        if (q <= SUM_W'(eps_shadow))
            return '0;
        if (acc[SUM_W-1])
            return (q >= 66'h8000_0000) ? 32'h8000_0000 : -q[WORD_W-1:0];
        return (q > 66'h7fff_ffff) ? 32'h7fff_ffff : q[WORD_W-1:0];
    endfunction

    // M*v walks a row (stride 4 in column-major), v*M walks a column
    function automatic t_quad transform_vector(input logic [1:0] act, input t_quad v);
        t_quad                    res;
        logic signed [SUM_W-1:0]  acc;
        logic signed [WORD_W-1:0] elem;
        logic signed [WORD_W-1:0] comp;
        logic signed [PROD_W-1:0] prod;
        int                       idx;
        for (int i = 0; i < LANES; i++) begin
            acc = '0;
            for (int j = 0; j < LANES; j++) begin
                idx  = (act == ACT_COL) ? i + 4 * j : 4 * i + j;
                elem = matrix_shadow[idx];
                comp = v[j];
                prod = elem * comp;
                acc  = acc + prod;
            end
            res[i] = fold_sum(acc);
        end
        return res;
    endfunction

    // apply one accepted beat to the shadow state
    function automatic void track_beat(input t_beat b);
        case (b.action)
            ACT_LOAD: matrix_shadow[b.elem_index] = b.elem_value;
            ACT_COL,
            ACT_ROW:  pending_vectors.push_back(transform_vector(b.action, b.vec));
            default:  ;  // dropped by the block
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_beat make_beat(input logic [1:0] act, input logic [3:0] idx,
                                        input logic [31:0] val, input t_quad v);
        t_beat b;
        b.action     = act;
        b.elem_index = idx;
        b.elem_value = val;
        b.vec        = v;
        return b;
    endfunction

    // mix of full-range words, moderate Q16.16 values, tiny raw values
    // near the snap threshold, and corner values
    function automatic logic [31:0] rand_word();
        int pick;
        pick = $urandom_range(9);
        if (pick < 3)
            return $urandom;
        if (pick < 6)
            return 32'($signed($urandom_range(2 * 1048576)) - 1048576);
        if (pick < 8)
            return 32'($signed($urandom_range(128)) - 64);
        case ($urandom_range(6))
            0:       return 32'h0000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h0001_0000;
            4:       return 32'hffff_0000;
            5:       return 32'h0000_ffff;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    function automatic t_beat rand_beat();
        t_beat b;
        int    roll;
        roll = $urandom_range(99);
        if (roll < 20)
            b.action = ACT_LOAD;
        else if (roll < 23)
            b.action = ACT_UNUSED;
        else if (roll < 62)
            b.action = ACT_COL;
        else
            b.action = ACT_ROW;
        b.elem_index = 4'($urandom);
        b.elem_value = rand_word();
        for (int k = 0; k < LANES; k++)
            b.vec[k] = rand_word();
        return b;
    endfunction

    // Holds tvalid high across back-to-back beats; only a gap lowers it.
    task automatic send_beat(input t_beat b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.action;
        s_tdata  <= {4'b0, b.vec, b.elem_value, b.elem_index};
        do
            @(posedge i_clk);
        while (!s_tready);
        track_beat(b);
    endtask

    // drop tvalid, let every predicted beat come out, then flush the pipe
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_vectors.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);  // register takes the write here
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr[2] == REG_ZERO_EPS)
            eps_shadow = data[EPS_W-1:0];
    endtask

    // read back zero_epsilon; sampled mid access phase
    task automatic check_eps_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ZERO_EPS;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata !== {16'b0, eps_shadow}) begin
            $display("%0t: zero_epsilon readback expected %h got %h",
                     $time, {16'b0, eps_shadow}, prdata);
            errors++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // identity after reset, snap at the reset epsilon, dropped code,
    // truncation toward zero, saturation both ways, loads at both index ends
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_beat(make_beat(ACT_COL, 4'h0, 32'h0,
                  {32'hffff_0000, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff}));
        send_beat(make_beat(ACT_ROW, 4'h0, 32'h0, {32'hffff_fff8, 32'd8, 32'hffff_fff9, 32'd7}));
        send_beat(make_beat(ACT_ROW, 4'h0, 32'h0, '0));
        send_beat(make_beat(ACT_UNUSED, 4'hf, 32'hffff_ffff, '1));
        // 1.5 * -11 raw = -16.5 raw, truncates to -16 (not -17)
        send_beat(make_beat(ACT_LOAD, 4'h0, 32'h0001_8000, '0));
        send_beat(make_beat(ACT_COL, 4'h0, 32'h0, {32'h0, 32'h0, 32'h0, 32'hffff_fff5}));
        send_beat(make_beat(ACT_LOAD, 4'h1, 32'h7fff_ffff, '1));
        send_beat(make_beat(ACT_LOAD, 4'h4, 32'h8000_0000, '1));
        send_beat(make_beat(ACT_LOAD, 4'hf, 32'hffff_0000, '0));
        send_beat(make_beat(ACT_COL, 4'h0, 32'h0, {4{32'h7fff_ffff}}));
        send_beat(make_beat(ACT_ROW, 4'h0, 32'h0, {4{32'h8000_0000}}));
        send_beat(make_beat(ACT_COL, 4'h0, 32'h0, {4{32'h8000_0000}}));
        send_beat(make_beat(ACT_ROW, 4'h0, 32'h0, {4{32'h7fff_ffff}}));
        send_beat(make_beat(ACT_LOAD, 4'ha, 32'hffff_ffff, '0));
        send_beat(make_beat(ACT_LOAD, 4'h5, 32'h0000_0000, '0));
        send_beat(make_beat(ACT_ROW, 4'h0, 32'h0,
                  {32'hffff_0000, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000}));
        // first row max but for element 4 (the minimum): M*v with max vector still blows past 2^31 in lane 0
        send_beat(make_beat(ACT_LOAD, 4'h0, 32'h7fff_ffff, '0));
        send_beat(make_beat(ACT_LOAD, 4'h8, 32'h7fff_ffff, '0));
        send_beat(make_beat(ACT_LOAD, 4'hc, 32'h7fff_ffff, '0));
        send_beat(make_beat(ACT_COL, 4'h0, 32'h0, {4{32'h7fff_ffff}}));
        send_beat(make_beat(ACT_COL, 4'h0, 32'h0, {4{32'h8000_0000}}));
        drain();
    endtask

    // reset value reads back, the empty slot ignores writes, upper bits masked
    task automatic test_register_access();
        check_eps_readback();
        apb_write(ADDR_NO_REG, 32'hffff_ffff);
        check_eps_readback();
        apb_write(ADDR_ZERO_EPS, 32'hdead_0000);
        check_eps_readback();
        apb_write(ADDR_ZERO_EPS, 32'h0000_0007);
        check_eps_readback();
    endtask

    task automatic test_random_phase(input logic [EPS_W-1:0] eps, input int idle_pct,
                                     input int stall_pct);
        t_beat b;
        int    counted;
        drain();
        apb_write(ADDR_ZERO_EPS, {16'($urandom), eps});
        check_eps_readback();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        counted        = 0;
        while (counted < PHASE_BEATS) begin
            b = rand_beat();
            send_beat(b);
            if (b.action != ACT_UNUSED)
                counted++;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random backpressure and the lane-by-lane check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : out_check
        t_quad got;
        t_quad want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_vectors.size() == 0) begin
                    $display("%0t: output beat with none expected, got %h", $time, got);
                    errors++;
                end else begin
                    want = pending_vectors.pop_front();
                    for (int k = 0; k < LANES; k++)
                        if (got[k] !== want[k]) begin
                            $display("%0t: lane %0d expected %h got %h",
                                     $time, k, want[k], got[k]);
                            errors++;
                        end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hang detector: any beat or APB access counts as progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("tb_matrix_vector_transform: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < MATRIX_ELEMS; i++)
            matrix_shadow[i] = '0;
        matrix_shadow[0]  = 32'h1 << FRAC_BITS;
        matrix_shadow[5]  = 32'h1 << FRAC_BITS;
        matrix_shadow[10] = 32'h1 << FRAC_BITS;
        matrix_shadow[15] = 32'h1 << FRAC_BITS;
        eps_shadow        = 16'd7;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_register_access();
        // sender mostly busy, receiver stalls most of the time
        test_random_phase(16'd0, 7, 64);
        // sender gappy, receiver mostly ready
        test_random_phase(16'hffff, 64, 7);
        // full rate both ways
        test_random_phase(16'($urandom_range(65535)), 0, 0);
        drain();

        if (errors == 0)
            $display("tb_matrix_vector_transform: clean");
        else
            $display("tb_matrix_vector_transform: errors");
        $finish;
    end

endmodule

/* matrix_vector_transform.f */
rtl/mvt_pkg.sv
rtl/mvt_lane.sv
rtl/matrix_vector_transform.sv
dv/tb_matrix_vector_transform.sv
